// ===== rtl/obmm_pkg.sv =====
// ----------------------------------------------------------------------------
// obmm_pkg
// Shared types and constants of the outage bitmap merge unit: field widths,
// controller states, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package obmm_pkg;

  // Default bitmap size in bytes (one bit per station index)
  localparam int unsigned BITMAP_BYTES_DEF = 256;

  // Field widths
  localparam int unsigned IDX_OUT_W   = 11;
  localparam int unsigned START_W     = 16;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 2 * BYTE_W;
  // Byte address wide enough for any start + 8*position, plus one
  localparam int unsigned BYTE_ADDR_W = 14;
  localparam int unsigned WIDE_IDX_W  = BYTE_ADDR_W + 3;

  // Reset value of the lowest search start register
  localparam logic [IDX_OUT_W-1:0] SEARCH_START_RST = 11'd2;

  // Item modes
  localparam logic MODE_MERGE = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Address width of a store of the given depth, at least one bit
  function automatic int unsigned addr_w(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD_HI,
    ST_WR_HI,
    ST_CLEAR,
    ST_SCAN,
    ST_FINISH
  } obmm_state_e;

  typedef struct packed {
    logic accept;      // transfer of an input item this cycle
    logic rd_hi;       // write low byte, read high byte
    logic wr_hi;       // write high byte, update summary
    logic scan_start;  // begin a lowest-index scan
    logic scan_run;    // advance the lowest-index scan
    logic clr_step;    // clear one bitmap byte
    logic out_load;    // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic mode;        // mode of the item offered at the input
    logic stale;       // lowest index no longer matches the search start
    logic scan_done;   // scan pipeline has drained
    logic clr_last;    // clear pointer sits on the last byte
  } dp_sts_t;

endpackage

// ===== rtl/obmm_ram.sv =====
// ----------------------------------------------------------------------------
// obmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module obmm_ram import obmm_pkg::*; #(
  parameter int unsigned WIDTH = BYTE_W,
  parameter int unsigned DEPTH = BITMAP_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [addr_w(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       re_i,
  input  logic [addr_w(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/obmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// obmm_ctrl
// Sequencer of the outage bitmap merge unit: steps each item through the
// read-modify-write of its two bitmap bytes, the clearing sweep or the
// lowest-index scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module obmm_ctrl import obmm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  obmm_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (sts_i.mode == MODE_CLEAR) ? ST_CLEAR : ST_RD_HI;
        end
      end
      ST_RD_HI: state_d = ST_WR_HI;
      ST_WR_HI: state_d = sts_i.stale ? ST_SCAN : ST_FINISH;
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_FINISH;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT:  cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_RD_HI: cmd_o.rd_hi = 1'b1;
      ST_WR_HI: begin
        cmd_o.wr_hi      = 1'b1;
        cmd_o.scan_start = sts_i.stale;
      end
      ST_CLEAR:  cmd_o.clr_step = 1'b1;
      ST_SCAN:   cmd_o.scan_run = 1'b1;
      ST_FINISH: cmd_o.out_load = !out_valid_q || out_ready_i;
      default:   cmd_o = '0;
    endcase
  end

  // Hold the result until its transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_wr_hi_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_HI) |-> ($past(state_q, 2) == ST_IDLE))
    else $error("high byte write not two cycles after a transfer");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result raised outside the finish step");

  a_leave_idle_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("left idle without an input transfer");
`endif

endmodule

// ===== rtl/obmm_dpath.sv =====
// ----------------------------------------------------------------------------
// obmm_dpath
// Datapath of the outage bitmap merge unit: bitmap RAM with its address and
// merge logic, search start register, running lowest / highest / any-set
// summary, scan pipeline and result register.
// ----------------------------------------------------------------------------
module obmm_dpath import obmm_pkg::*; #(
  parameter int unsigned BITMAP_BYTES = BITMAP_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic [IDX_OUT_W-1:0] cfg_wr_data_i,
  input  logic                 mode_i,
  input  logic [START_W-1:0]   start_index_i,
  input  logic [POS_W-1:0]     byte_position_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic                 last_byte_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  output logic [IDX_OUT_W-1:0] lowest_index_o,
  output logic [IDX_OUT_W-1:0] highest_index_o,
  output logic                 all_clear_o,
  output logic                 fragment_done_o
);

  localparam int unsigned AW = addr_w(BITMAP_BYTES);
  localparam int unsigned IW = $clog2(8 * BITMAP_BYTES);
  localparam logic [BYTE_ADDR_W-1:0] NUM_BYTES = BYTE_ADDR_W'(BITMAP_BYTES);
  localparam logic [AW-1:0]          LAST_BYTE = AW'(BITMAP_BYTES - 1);

  // First set bit, last set bit
  function automatic logic [3:0] lsb16(input logic [WORD_W-1:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] msb16(input logic [WORD_W-1:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  function automatic logic [2:0] lsb8(input logic [BYTE_W-1:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // Control and summary state
  logic [IDX_OUT_W-1:0]   search_start_q, search_start_d;
  logic                   stale_q, stale_d;
  logic                   lo_ok_q, lo_ok_d;
  logic                   hi_ok_q, hi_ok_d;
  logic [IW-1:0]          lowest_q, lowest_d;
  logic                   lowest_vld_q, lowest_vld_d;
  logic [IW-1:0]          highest_q, highest_d;
  logic                   any_q, any_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic                   issue_q, issue_d;
  logic                   chk_vld_q, chk_vld_d;

  // Payload registers
  logic [BYTE_ADDR_W-1:0] byte_lo_q, byte_lo_d;
  logic [BYTE_ADDR_W-1:0] byte_hi_q, byte_hi_d;
  logic [WORD_W-1:0]      word_q, word_d;
  logic [WORD_W-1:0]      lo_cand_q, hi_cand_q;
  logic                   last_q;
  logic [AW-1:0]          chk_addr_q, chk_addr_d;
  logic [IDX_OUT_W-1:0]   lowest_index_q, highest_index_q;
  logic                   all_clear_q, fragment_done_q;

  // RAM ports
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]      ram_wdata, ram_rdata;

  // Working values
  logic [WIDE_IDX_W-1:0]  in_idx;
  logic [WORD_W-1:0]      in_shifted;
  logic [WIDE_IDX_W-1:0]  base_idx;
  logic [WIDE_IDX_W-1:0]  s_wide;
  logic [WIDE_IDX_W:0]    s_diff;
  logic [WORD_W-1:0]      ge_mask, nz_mask;
  logic [WIDE_IDX_W-1:0]  lo_cand_idx, hi_cand_idx;
  logic [WIDE_IDX_W-1:0]  lowest_wide, highest_wide;
  logic [BYTE_ADDR_W-1:0] scan_first;
  logic                   chk_first;
  logic [BYTE_W-1:0]      chk_word;
  logic                   hit;
  logic [WIDE_IDX_W-1:0]  hit_idx;

  // Locate the two bytes touched by the offered item, drop bits past the end
  always_comb begin
    in_idx     = WIDE_IDX_W'(start_index_i) + (WIDE_IDX_W'(byte_position_i) << 3);
    byte_lo_d  = in_idx[WIDE_IDX_W-1:3];
    byte_hi_d  = byte_lo_d + 1'b1;
    lo_ok_d    = byte_lo_d < NUM_BYTES;
    hi_ok_d    = byte_hi_d < NUM_BYTES;
    in_shifted = WORD_W'(data_byte_i) << in_idx[2:0];
    word_d     = {hi_ok_d ? in_shifted[WORD_W-1:BYTE_W] : {BYTE_W{1'b0}},
                  lo_ok_d ? in_shifted[BYTE_W-1:0]      : {BYTE_W{1'b0}}};
  end

  // Eligibility masks of the new bits: at or above search start, above zero
  always_comb begin
    base_idx = {byte_lo_q, 3'b000};
    s_wide   = WIDE_IDX_W'(search_start_q);
    s_diff   = {1'b0, s_wide} - {1'b0, base_idx};
    if (s_diff[WIDE_IDX_W]) begin
      ge_mask = '1;
    end else if (|s_diff[WIDE_IDX_W-1:4]) begin
      ge_mask = '0;
    end else begin
      ge_mask = {WORD_W{1'b1}} << s_diff[3:0];
    end
    nz_mask = (base_idx == '0) ? {{(WORD_W-1){1'b1}}, 1'b0} : {WORD_W{1'b1}};
  end

  // Candidate indices from the merged word and from the scan
  always_comb begin
    lo_cand_idx  = base_idx + WIDE_IDX_W'(lsb16(lo_cand_q));
    hi_cand_idx  = base_idx + WIDE_IDX_W'(msb16(hi_cand_q));
    lowest_wide  = WIDE_IDX_W'(lowest_q);
    highest_wide = WIDE_IDX_W'(highest_q);
    scan_first   = BYTE_ADDR_W'(search_start_q[IDX_OUT_W-1:3]);
    chk_first    = BYTE_ADDR_W'(chk_addr_q) == scan_first;
    chk_word     = ram_rdata & (chk_first ? (8'hFF << search_start_q[2:0]) : 8'hFF);
    hit          = chk_vld_q && (|chk_word);
    hit_idx      = {BYTE_ADDR_W'(chk_addr_q), lsb8(chk_word)};
  end

  // Summary, scan and sweep state updates
  always_comb begin
    search_start_d = search_start_q;
    stale_d        = stale_q;
    lowest_d       = lowest_q;
    lowest_vld_d   = lowest_vld_q;
    highest_d      = highest_q;
    any_d          = any_q;
    ptr_d          = ptr_q;
    issue_d        = issue_q;
    chk_vld_d      = chk_vld_q;
    chk_addr_d     = chk_addr_q;

    if (cfg_wr_en_i) begin
      search_start_d = cfg_wr_data_i;
      stale_d        = 1'b1;
    end

    if (cmd_i.accept) begin
      ptr_d = '0;
    end

    // Fold the new bits into the running summary
    if (cmd_i.wr_hi) begin
      if ((|lo_cand_q) && (!lowest_vld_q || (lo_cand_idx < lowest_wide))) begin
        lowest_d     = lo_cand_idx[IW-1:0];
        lowest_vld_d = 1'b1;
      end
      if ((|hi_cand_q) && (hi_cand_idx > highest_wide)) begin
        highest_d = hi_cand_idx[IW-1:0];
      end
      any_d = any_q | (|word_q);
    end

    // Restart the lowest search from the search start byte
    if (cmd_i.scan_start) begin
      lowest_vld_d = 1'b0;
      stale_d      = 1'b0;
      ptr_d        = scan_first[AW-1:0];
      issue_d      = scan_first < NUM_BYTES;
      chk_vld_d    = 1'b0;
    end

    // Advance the scan: issue one read, check the byte read last cycle
    if (cmd_i.scan_run) begin
      chk_vld_d  = issue_q;
      chk_addr_d = ptr_q;
      if (issue_q) begin
        if (ptr_q == LAST_BYTE) begin
          issue_d = 1'b0;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      if (hit) begin
        lowest_d     = hit_idx[IW-1:0];
        lowest_vld_d = 1'b1;
        issue_d      = 1'b0;
        chk_vld_d    = 1'b0;
      end
    end

    // Sweep one byte to zero and drop the summary
    if (cmd_i.clr_step) begin
      ptr_d        = (ptr_q == LAST_BYTE) ? '0 : ptr_q + 1'b1;
      lowest_vld_d = 1'b0;
      highest_d    = '0;
      any_d        = 1'b0;
      stale_d      = 1'b0;
    end
  end

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;
    if (cmd_i.accept) begin
      ram_re    = lo_ok_d;
      ram_raddr = byte_lo_d[AW-1:0];
    end
    if (cmd_i.rd_hi) begin
      ram_we    = lo_ok_q;
      ram_waddr = byte_lo_q[AW-1:0];
      ram_wdata = ram_rdata | word_q[BYTE_W-1:0];
      ram_re    = hi_ok_q;
      ram_raddr = byte_hi_q[AW-1:0];
    end
    if (cmd_i.wr_hi) begin
      ram_we    = hi_ok_q;
      ram_waddr = byte_hi_q[AW-1:0];
      ram_wdata = ram_rdata | word_q[WORD_W-1:BYTE_W];
    end
    if (cmd_i.scan_run) begin
      ram_re = issue_q;
    end
    if (cmd_i.clr_step) begin
      ram_we = 1'b1;
    end
  end

  obmm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control and summary registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_start_q <= SEARCH_START_RST;
      stale_q        <= 1'b0;
      lo_ok_q        <= 1'b0;
      hi_ok_q        <= 1'b0;
      lowest_q       <= '0;
      lowest_vld_q   <= 1'b0;
      highest_q      <= '0;
      any_q          <= 1'b0;
      ptr_q          <= '0;
      issue_q        <= 1'b0;
      chk_vld_q      <= 1'b0;
    end else begin
      search_start_q <= search_start_d;
      stale_q        <= stale_d;
      if (cmd_i.accept) begin
        lo_ok_q <= lo_ok_d;
        hi_ok_q <= hi_ok_d;
      end
      lowest_q     <= lowest_d;
      lowest_vld_q <= lowest_vld_d;
      highest_q    <= highest_d;
      any_q        <= any_d;
      ptr_q        <= ptr_d;
      issue_q      <= issue_d;
      chk_vld_q    <= chk_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_lo_q <= byte_lo_d;
      byte_hi_q <= byte_hi_d;
      word_q    <= word_d;
      last_q    <= last_byte_i;
    end
    if (cmd_i.rd_hi) begin
      lo_cand_q <= word_q & ge_mask;
      hi_cand_q <= word_q & nz_mask;
    end
    chk_addr_q <= chk_addr_d;
    if (cmd_i.out_load) begin
      lowest_index_q  <= lowest_vld_q ? lowest_wide[IDX_OUT_W-1:0] : '0;
      highest_index_q <= highest_wide[IDX_OUT_W-1:0];
      all_clear_q     <= !any_q;
      fragment_done_q <= last_q;
    end
  end

  assign sts_o.mode      = mode_i;
  assign sts_o.stale     = stale_q;
  assign sts_o.scan_done = !issue_q && !chk_vld_q;
  assign sts_o.clr_last  = ptr_q == LAST_BYTE;

  assign lowest_index_o  = lowest_index_q;
  assign highest_index_o = highest_index_q;
  assign all_clear_o     = all_clear_q;
  assign fragment_done_o = fragment_done_q;

`ifndef ASSERT_OFF
  a_highest_drops_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (highest_q < $past(highest_q)) |-> $past(cmd_i.clr_step))
    else $error("highest index fell without a clear");

  a_empty_has_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> ((highest_q == '0) && !lowest_vld_q))
    else $error("index tracked while bitmap is empty");

  a_lowest_above_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lowest_vld_q && !stale_q) |-> (lowest_wide >= s_wide))
    else $error("lowest index below search start");
`endif

endmodule

// ===== rtl/outage_bitmap_merge_minmax_unit.sv =====
// ----------------------------------------------------------------------------
// outage_bitmap_merge_minmax_unit
// Outage bitmap of station indices with OR-merge of fragment bytes, clear,
// and running lowest / highest set index.
// ----------------------------------------------------------------------------
// A merge item goes from its input transfer to its result in the output
// register through its steps in order (read low byte, write low byte and
// read high byte, write high byte, load result); the load waits while an
// earlier result is held and not yet taken, and no new item is taken until
// the result is loaded. The first merge item after a write of the search
// start register, unless a clear item comes between, adds a scan before the
// load that reads the bitmap byte by byte from the search start byte up to
// the first set bit. A clear item sweeps the RAM one byte a cycle. After
// reset a clearing pass over the whole bitmap runs before the first input
// transfer; register writes are taken during it. Bits that land past the
// end of the bitmap are dropped; indices are reported in 11 bits.
// ----------------------------------------------------------------------------
module outage_bitmap_merge_minmax_unit import obmm_pkg::*; #(
  parameter int unsigned BITMAP_BYTES = BITMAP_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration
  input  logic                 cfg_wr_en_i,
  input  logic [IDX_OUT_W-1:0] cfg_wr_data_i,
  // Input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [START_W-1:0]   start_index_i,
  input  logic [POS_W-1:0]     byte_position_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic                 last_byte_i,
  // Results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IDX_OUT_W-1:0] lowest_index_o,
  output logic [IDX_OUT_W-1:0] highest_index_o,
  output logic                 all_clear_o,
  output logic                 fragment_done_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  obmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Bitmap store and summary
  obmm_dpath #(
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .mode_i          (mode_i),
    .start_index_i   (start_index_i),
    .byte_position_i (byte_position_i),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .lowest_index_o  (lowest_index_o),
    .highest_index_o (highest_index_o),
    .all_clear_o     (all_clear_o),
    .fragment_done_o (fragment_done_o)
  );

endmodule
